[design/tnsit_pkg.sv]
// Package for the top-N sorted insert table.
// Holds the command codes, the controller command struct and the name packing
// function. It depends on nothing else.
package tnsit_pkg;

  localparam int SCORE_W = 48;
  localparam int NAME_W  = 64;
  localparam int STAMP_W = 32;
  localparam int RANK_W  = 3;
  localparam int FILL_W  = 4;

  localparam logic [NAME_W-1:0] EMPTY_NAME = 64'h0000_0059_5450_4D45;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  // Keeps the first nbytes bytes and clears everything from the first zero byte.
  function automatic logic [NAME_W-1:0] pack_name(input logic [NAME_W-1:0] raw,
                                                  input int nbytes);
    logic [NAME_W-1:0] kept;
    logic              stop;
    kept = '0;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (b >= nbytes || raw[8*b +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        kept[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return kept;
  endfunction

endpackage

[design/top_n_sorted_insert_table.sv]
// Top level of the top-N sorted insert table: a sorted leaderboard of scored entries.
// Joins the controller and the datapath. Depends on tnsit_pkg, tnsit_ctrl and tnsit_dp.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid, in_stall   command, new_score, name_tag, stamp, read_rank
//   out_     output     out_valid, out_stall accepted, placed_rank, entry_*, filled
//
// Each item is first captured and then executed: all entries are compared with the
// new score at once and the store shifts.
// After reset every entry holds score zero, the name EMPTY and stamp zero.
// A finished result waits in the output register; the next item is still taken,
// but its execution waits until that register is free.
module top_n_sorted_insert_table
  import tnsit_pkg::*;
#(
  parameter int DEPTH      = 8,
  parameter int NAME_BYTES = 8
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [SCORE_W-1:0] in_new_score,
  input  logic [NAME_W-1:0]  in_name_tag,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic [RANK_W-1:0]  in_read_rank,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [RANK_W-1:0]  out_placed_rank,
  output logic [SCORE_W-1:0] out_entry_score,
  output logic [NAME_W-1:0]  out_entry_name,
  output logic [STAMP_W-1:0] out_entry_stamp,
  output logic [FILL_W-1:0]  out_filled
);

  dp_cmd_t dp_cmd;

  tnsit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  tnsit_dp #(
    .DEPTH      (DEPTH),
    .NAME_BYTES (NAME_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .dp_cmd          (dp_cmd),
    .in_command      (in_command),
    .in_new_score    (in_new_score),
    .in_name_tag     (in_name_tag),
    .in_stamp        (in_stamp),
    .in_read_rank    (in_read_rank),
    .out_accepted    (out_accepted),
    .out_placed_rank (out_placed_rank),
    .out_entry_score (out_entry_score),
    .out_entry_name  (out_entry_name),
    .out_entry_stamp (out_entry_stamp),
    .out_filled      (out_filled)
  );

endmodule

[design/tnsit_ctrl.sv]
// Controller of the top-N sorted insert table.
// Sequences capture and execution of one item and owns the result valid flag.
// Depends on tnsit_pkg.
module tnsit_ctrl
  import tnsit_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t dp_cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    dp_cmd.load = 1'b0;
    dp_cmd.exec = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          dp_cmd.exec = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[design/tnsit_dp.sv]
// Datapath of the top-N sorted insert table.
// Holds the captured item, the sorted entry store, the fill count and the
// result registers. Depends on tnsit_pkg.
module tnsit_dp
  import tnsit_pkg::*;
#(
  parameter int DEPTH      = 8,
  parameter int NAME_BYTES = 8
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            dp_cmd,
  input  logic               in_command,
  input  logic [SCORE_W-1:0] in_new_score,
  input  logic [NAME_W-1:0]  in_name_tag,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic [RANK_W-1:0]  in_read_rank,
  output logic               out_accepted,
  output logic [RANK_W-1:0]  out_placed_rank,
  output logic [SCORE_W-1:0] out_entry_score,
  output logic [NAME_W-1:0]  out_entry_name,
  output logic [STAMP_W-1:0] out_entry_stamp,
  output logic [FILL_W-1:0]  out_filled
);

  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  cmd_t               op_cmd_r;
  logic [SCORE_W-1:0] op_score_r;
  logic [NAME_W-1:0]  op_name_r;
  logic [STAMP_W-1:0] op_stamp_r;
  logic [RANK_W-1:0]  op_rank_r;

  logic [SCORE_W-1:0] score_r [DEPTH];
  logic [NAME_W-1:0]  name_r  [DEPTH];
  logic [STAMP_W-1:0] stamp_r [DEPTH];
  logic [SCORE_W-1:0] score_nxt [DEPTH];
  logic [NAME_W-1:0]  name_nxt  [DEPTH];
  logic [STAMP_W-1:0] stamp_nxt [DEPTH];
  logic [CNTW-1:0]    count_r, count_nxt;

  logic               full;
  logic               hit;
  logic               ins_ok;
  logic [IDXW-1:0]    pos;
  logic [NAME_W-1:0]  packed_name;
  logic [SCORE_W-1:0] rd_score;
  logic [NAME_W-1:0]  rd_name;
  logic [STAMP_W-1:0] rd_stamp;

  logic               res_accepted;
  logic [RANK_W-1:0]  res_placed;
  logic [SCORE_W-1:0] res_score;
  logic [NAME_W-1:0]  res_name;
  logic [STAMP_W-1:0] res_stamp;

  assign full        = (count_r >= CNTW'(DEPTH));
  assign packed_name = pack_name(op_name_r, NAME_BYTES);

  // The valid part is sorted, so the first smaller entry marks the insert point.
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!hit && (CNTW'(i) < count_r) && (op_score_r > score_r[i])) begin
        hit = 1'b1;
        pos = IDXW'(i);
      end
    end
    if (!hit && !full) begin
      pos = IDXW'(count_r);
    end
    ins_ok = hit || !full;
  end

  always_comb begin
    rd_score = '0;
    rd_name  = '0;
    rd_stamp = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (int'(op_rank_r) == i) begin
        rd_score = score_r[i];
        rd_name  = name_r[i];
        rd_stamp = stamp_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      score_nxt[i] = score_r[i];
      name_nxt[i]  = name_r[i];
      stamp_nxt[i] = stamp_r[i];
    end
    count_nxt = count_r;
    if (op_cmd_r == CMD_INSERT && ins_ok) begin
      if (pos == '0) begin
        score_nxt[0] = op_score_r;
        name_nxt[0]  = packed_name;
        stamp_nxt[0] = op_stamp_r;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (IDXW'(i) == pos) begin
          score_nxt[i] = op_score_r;
          name_nxt[i]  = packed_name;
          stamp_nxt[i] = op_stamp_r;
        end else if (IDXW'(i) > pos) begin
          score_nxt[i] = score_r[i-1];
          name_nxt[i]  = name_r[i-1];
          stamp_nxt[i] = stamp_r[i-1];
        end
      end
      if (!full) begin
        count_nxt = count_r + CNTW'(1);
      end
    end
  end

  always_comb begin
    res_accepted = 1'b0;
    res_placed   = '0;
    res_score    = '0;
    res_name     = '0;
    res_stamp    = '0;
    if (op_cmd_r == CMD_READ) begin
      res_score = rd_score;
      res_name  = rd_name;
      res_stamp = rd_stamp;
    end else if (ins_ok) begin
      res_accepted = 1'b1;
      res_placed   = RANK_W'(pos);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op_cmd_r   <= cmd_t'(in_command);
      op_score_r <= in_new_score;
      op_name_r  <= in_name_tag;
      op_stamp_r <= in_stamp;
      op_rank_r  <= in_read_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        score_r[i] <= '0;
        name_r[i]  <= pack_name(EMPTY_NAME, NAME_BYTES);
        stamp_r[i] <= '0;
      end
      count_r <= '0;
    end else if (dp_cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        score_r[i] <= score_nxt[i];
        name_r[i]  <= name_nxt[i];
        stamp_r[i] <= stamp_nxt[i];
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      out_accepted    <= res_accepted;
      out_placed_rank <= res_placed;
      out_entry_score <= res_score;
      out_entry_name  <= res_name;
      out_entry_stamp <= res_stamp;
      out_filled      <= FILL_W'(count_nxt);
    end
  end

endmodule
